// ===== hw/rtl/xy_stepper_move_controller_core_macros.svh =====
// Assertion macros shared by the stepper move controller RTL.
`ifndef XY_STEPPER_MOVE_CONTROLLER_CORE_MACROS_SVH
`define XY_STEPPER_MOVE_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define XYSMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define XYSMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/xysmc_pkg.sv =====
// Types, constants and helpers shared by the stepper move controller.
`timescale 1ns / 1ps
package xysmc_pkg;

  localparam int unsigned POS_WIDTH_DEF   = 20;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned LIMIT_W         = 20;
  localparam int unsigned SPU_W           = 24;
  localparam int unsigned TARGET_W        = 20;
  localparam int unsigned OUT_POS_W       = 20;
  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 24;
  localparam int unsigned IN_TDATA_W      = 48;
  localparam int unsigned IN_TUSER_W      = 2;
  localparam int unsigned OUT_TDATA_W     = 48;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 20'd10000;
  localparam logic [SPU_W-1:0]   SPU_RST   = 24'd25600;

  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPU     = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_HOME = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_MOVE,
    KIND_HOME,
    KIND_NONE
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_MOVE,
    MODE_HOME_Y,
    MODE_HOME_X
  } mode_e;

  typedef struct packed {
    kind_e kind;
    logic  x_switch;
    logic  y_switch;
  } cmd_t;

  typedef struct packed {
    logic rejected;
    logic busy;
    logic y_dir;
    logic x_dir;
    logic y_step;
    logic x_step;
  } status_t;

  // Limit clipped to the largest position a pw-bit counter can hold.
  function automatic logic [LIMIT_W-1:0] sat_limit(input logic [LIMIT_W-1:0] lim,
                                                   input int unsigned pw);
    logic [LIMIT_W-1:0] cap;
    cap = '1;
    if (pw < LIMIT_W) begin
      cap = (LIMIT_W'(1) << pw) - LIMIT_W'(1);
    end
    return (lim > cap) ? cap : lim;
  endfunction

endpackage

// ===== hw/rtl/xysmc_front.sv =====
// Front end: accepts beats, classifies the op and scales move targets to steps.
`timescale 1ns / 1ps
module xysmc_front
  import xysmc_pkg::*;
#(
  parameter int unsigned PosWidth = POS_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  logic signed [TARGET_W-1:0] target_x_i,
  input  logic signed [TARGET_W-1:0] target_y_i,
  input  logic                       x_switch_i,
  input  logic                       y_switch_i,
  input  logic [LIMIT_W-1:0]         x_limit_i,
  input  logic [LIMIT_W-1:0]         y_limit_i,
  input  logic [SPU_W-1:0]           spu_i,
  input  logic                       full_i,
  output logic                       push_o,
  output cmd_t                       cmd_o,
  output logic [PosWidth-1:0]        steps_x_o,
  output logic [PosWidth-1:0]        steps_y_o
);

  localparam int unsigned MagW  = TARGET_W - 1;
  localparam int unsigned ProdW = MagW + SPU_W;
  localparam int unsigned StepW = ProdW - FRAC_BITS;
  localparam logic [ProdW-1:0] RoundHalf = ProdW'(1) << (FRAC_BITS - 1);

  logic              valid_q;
  cmd_t              cmd_q;
  cmd_t              cmd_d;
  logic [ProdW-1:0]  prod_x_q, prod_y_q;
  logic [MagW-1:0]   mag_x, mag_y;
  logic              load;

  function automatic logic [PosWidth-1:0] scale_axis(input logic [ProdW-1:0] prod,
                                                     input logic [LIMIT_W-1:0] lim);
    logic [ProdW-1:0] sum;
    logic [StepW-1:0] steps;
    logic [StepW-1:0] lim_w;
    sum   = prod + RoundHalf;
    steps = sum[ProdW-1:FRAC_BITS];
    lim_w = StepW'(sat_limit(lim, PosWidth));
    if (steps > lim_w) begin
      steps = lim_w;
    end
    return PosWidth'(steps);
  endfunction

  // negative targets scale to zero
  assign mag_x = target_x_i[TARGET_W-1] ? '0 : target_x_i[MagW-1:0];
  assign mag_y = target_y_i[TARGET_W-1] ? '0 : target_y_i[MagW-1:0];

  always_comb begin
    cmd_d.x_switch = x_switch_i;
    cmd_d.y_switch = y_switch_i;
    case (op_i)
      OP_TICK: cmd_d.kind = KIND_TICK;
      OP_MOVE: cmd_d.kind = KIND_MOVE;
      OP_HOME: cmd_d.kind = KIND_HOME;
      default: cmd_d.kind = KIND_NONE;
    endcase
  end

  assign in_ready_o = !valid_q || !full_i;
  assign load       = in_valid_i && in_ready_o;
  assign push_o     = valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= load || (valid_q && !push_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q    <= cmd_d;
      prod_x_q <= ProdW'(mag_x) * ProdW'(spu_i);
      prod_y_q <= ProdW'(mag_y) * ProdW'(spu_i);
    end
  end

  assign cmd_o     = cmd_q;
  assign steps_x_o = scale_axis(prod_x_q, x_limit_i);
  assign steps_y_o = scale_axis(prod_y_q, y_limit_i);

endmodule

// ===== hw/rtl/xysmc_queue.sv =====
// Small FIFO between the front end and the motion back end.
`timescale 1ns / 1ps
module xysmc_queue
  import xysmc_pkg::*;
#(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

`include "xy_stepper_move_controller_core_macros.svh"

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `XYSMC_ASSERT_IMP(a_no_pop_empty, pop_i, valid_o, "pop from empty queue")
  `XYSMC_ASSERT_NXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "count lost a push")

endmodule

// ===== hw/rtl/xysmc_back.sv =====
// Back end: motion state machine, step generation and the output register.
`timescale 1ns / 1ps
module xysmc_back
  import xysmc_pkg::*;
#(
  parameter int unsigned PosWidth = POS_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  cmd_t                 cmd_i,
  input  logic [PosWidth-1:0]  steps_x_i,
  input  logic [PosWidth-1:0]  steps_y_i,
  input  logic [LIMIT_W-1:0]   x_limit_i,
  input  logic [LIMIT_W-1:0]   y_limit_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output status_t              status_o,
  output logic [OUT_POS_W-1:0] pos_x_o,
  output logic [OUT_POS_W-1:0] pos_y_o
);

`include "xy_stepper_move_controller_core_macros.svh"

  mode_e               mode_q, mode_d;
  logic [PosWidth-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [PosWidth-1:0] left_x_q, left_x_d, left_y_q, left_y_d;
  logic                dir_x_q, dir_x_d, dir_y_q, dir_y_d;
  logic                turn_q, turn_d;
  logic                xs, ys, rej, do_x;
  logic                fire;
  logic [PosWidth-1:0] lim_x, lim_y;
  logic                fwd_x, fwd_y;
  logic [PosWidth-1:0] dist_x, dist_y;
  logic                out_valid_q;
  status_t             status_q;
  logic [OUT_POS_W-1:0] pos_x_q, pos_y_q;

  assign fire  = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = fire;

  assign lim_x  = PosWidth'(sat_limit(x_limit_i, PosWidth));
  assign lim_y  = PosWidth'(sat_limit(y_limit_i, PosWidth));
  assign fwd_x  = steps_x_i > cur_x_q;
  assign fwd_y  = steps_y_i > cur_y_q;
  assign dist_x = fwd_x ? steps_x_i - cur_x_q : cur_x_q - steps_x_i;
  assign dist_y = fwd_y ? steps_y_i - cur_y_q : cur_y_q - steps_y_i;
  assign do_x   = (left_x_q != '0 && left_y_q != '0) ? !turn_q : (left_x_q != '0);

  always_comb begin
    mode_d   = mode_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    left_x_d = left_x_q;
    left_y_d = left_y_q;
    dir_x_d  = dir_x_q;
    dir_y_d  = dir_y_q;
    turn_d   = turn_q;
    xs       = 1'b0;
    ys       = 1'b0;
    rej      = 1'b0;
    case (cmd_i.kind)
      KIND_MOVE, KIND_HOME: begin
        if (mode_q != MODE_IDLE) begin
          rej = 1'b1;
        end else if (cmd_i.kind == KIND_MOVE) begin
          cur_x_d  = steps_x_i;
          cur_y_d  = steps_y_i;
          left_x_d = dist_x;
          left_y_d = dist_y;
          dir_x_d  = fwd_x;
          dir_y_d  = fwd_y;
          turn_d   = 1'b0;
          mode_d   = (dist_x != '0 || dist_y != '0) ? MODE_MOVE : MODE_IDLE;
        end else begin
          dir_x_d = 1'b1;
          dir_y_d = 1'b1;
          mode_d  = MODE_HOME_Y;
        end
      end
      KIND_TICK: begin
        case (mode_q)
          MODE_MOVE: begin
            if (do_x) begin
              xs       = 1'b1;
              left_x_d = left_x_q - 1'b1;
              turn_d   = 1'b1;
            end else if (left_y_q != '0) begin
              ys       = 1'b1;
              left_y_d = left_y_q - 1'b1;
              turn_d   = 1'b0;
            end
            if (left_x_d == '0 && left_y_d == '0) begin
              mode_d = MODE_IDLE;
            end
          end
          MODE_HOME_Y: begin
            if (cmd_i.y_switch) begin
              dir_y_d = 1'b1;
              ys      = 1'b1;
            end else begin
              mode_d = MODE_HOME_X;
            end
          end
          MODE_HOME_X: begin
            if (cmd_i.x_switch) begin
              dir_x_d = 1'b1;
              xs      = 1'b1;
            end else begin
              // homed: position is the limits, run back to the origin
              cur_x_d  = '0;
              cur_y_d  = '0;
              left_x_d = lim_x;
              left_y_d = lim_y;
              dir_x_d  = 1'b0;
              dir_y_d  = 1'b0;
              turn_d   = 1'b0;
              mode_d   = (lim_x != '0 || lim_y != '0) ? MODE_MOVE : MODE_IDLE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (fire) begin
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      left_x_q <= '0;
      left_y_q <= '0;
      dir_x_q  <= 1'b0;
      dir_y_q  <= 1'b0;
      turn_q   <= 1'b0;
    end else if (fire) begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      left_x_q <= left_x_d;
      left_y_q <= left_y_d;
      dir_x_q  <= dir_x_d;
      dir_y_q  <= dir_y_d;
      turn_q   <= turn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q.x_step   <= xs;
      status_q.y_step   <= ys;
      status_q.x_dir    <= dir_x_d;
      status_q.y_dir    <= dir_y_d;
      status_q.busy     <= (mode_d != MODE_IDLE);
      status_q.rejected <= rej;
      pos_x_q           <= OUT_POS_W'(cur_x_d);
      pos_y_q           <= OUT_POS_W'(cur_y_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;

  `XYSMC_ASSERT_IMP(a_one_axis_per_beat, fire, !(xs && ys), "both axes stepped in one beat")
  `XYSMC_ASSERT_IMP(a_idle_no_steps_left, mode_q == MODE_IDLE, left_x_q == '0 && left_y_q == '0, "idle with steps left")
  `XYSMC_ASSERT_IMP(a_reject_when_busy, out_valid_q && status_q.rejected, status_q.busy, "reject while not busy")
  `XYSMC_ASSERT_NXT(a_reject_holds_mode, fire && rej, mode_q == $past(mode_q), "rejected beat changed mode")

endmodule

// ===== hw/rtl/xy_stepper_move_controller_core.sv =====
// Two-axis stepper move controller with homing: top level.
//
// One input beat gives exactly one output beat, in order. The block sustains
// one beat per clock on both sides while m_axis_tready is high; a beat runs
// through the input register (target multiply), the front/back queue (round
// and clamp on write) and the motion back end into the output register. The
// once-per-beat update of the motion state in the back end sets this rate.
// tuser carries the op (0 tick, 1 move, 2 home, 3 ignored). Configuration is
// to be written through cfg_* only while no beat is in flight; the block does
// not enforce this. Index 0 X limit, 1 Y limit, 2 steps per unit (Q8.16).
`timescale 1ns / 1ps
module xy_stepper_move_controller_core
  import xysmc_pkg::*;
#(
  parameter int unsigned PosWidth   = POS_WIDTH_DEF,
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // target_x[19:0], target_y[39:20], x_switch[40], y_switch[41], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // x_step[0], y_step[1], x_dir[2], y_dir[3], busy_res[4], rejected[5],
  // pos_x[25:6], pos_y[45:26], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned QueueW = $bits(cmd_t) + 2 * PosWidth;
  localparam int unsigned PadW   = OUT_TDATA_W - $bits(status_t) - 2 * OUT_POS_W;

  logic [LIMIT_W-1:0]  x_limit_q, y_limit_q;
  logic [SPU_W-1:0]    spu_q;

  logic signed [TARGET_W-1:0] target_x, target_y;
  logic                push, full, pop, q_valid;
  cmd_t                f_cmd, b_cmd;
  logic [PosWidth-1:0] f_steps_x, f_steps_y, b_steps_x, b_steps_y;
  logic [QueueW-1:0]   q_wdata, q_rdata;
  status_t             status;
  logic [OUT_POS_W-1:0] pos_x, pos_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q <= LIMIT_RST;
      y_limit_q <= LIMIT_RST;
      spu_q     <= SPU_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_LIMIT: x_limit_q <= cfg_data_i[LIMIT_W-1:0];
        REG_Y_LIMIT: y_limit_q <= cfg_data_i[LIMIT_W-1:0];
        REG_SPU:     spu_q     <= cfg_data_i[SPU_W-1:0];
        default: ;
      endcase
    end
  end

  assign target_x = s_axis_tdata[TARGET_W-1:0];
  assign target_y = s_axis_tdata[2*TARGET_W-1:TARGET_W];

  xysmc_front #(
    .PosWidth (PosWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser[1:0]),
    .target_x_i (target_x),
    .target_y_i (target_y),
    .x_switch_i (s_axis_tdata[2*TARGET_W]),
    .y_switch_i (s_axis_tdata[2*TARGET_W+1]),
    .x_limit_i  (x_limit_q),
    .y_limit_i  (y_limit_q),
    .spu_i      (spu_q),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (f_cmd),
    .steps_x_o  (f_steps_x),
    .steps_y_o  (f_steps_y)
  );

  assign q_wdata = {f_cmd, f_steps_y, f_steps_x};

  xysmc_queue #(
    .Width (QueueW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  assign {b_cmd, b_steps_y, b_steps_x} = q_rdata;

  xysmc_back #(
    .PosWidth (PosWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (b_cmd),
    .steps_x_i   (b_steps_x),
    .steps_y_i   (b_steps_y),
    .x_limit_i   (x_limit_q),
    .y_limit_i   (y_limit_q),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y)
  );

  assign m_axis_tdata = {{PadW{1'b0}}, pos_y, pos_x, status};

endmodule
